[rtl/svr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper velocity ramp package
// Shared widths, register map and reset values for the stepper ramp block.
// ----------------------------------------------------------------------------
package svr_pkg;

  // Widths of the item fields and of the configuration port.
  localparam int unsigned SpeedW  = 32;
  localparam int unsigned RegW    = 31;
  localparam int unsigned PeriodW = 20;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 5;

  // Travel per step is scaled by this to compare against ticks times speed.
  localparam int unsigned StepScale = 1000000;
  localparam int unsigned ScaledW   = 51;

  // Reset values of the non-zero registers.
  localparam logic [PeriodW-1:0] UpdatePeriodRst  = 20'd1000;
  localparam logic [RegW-1:0]    TravelPerStepRst = 31'd65536;
  localparam logic [ScaledW-1:0] TravelScaledRst  = 51'd65536000000;

  typedef logic signed [SpeedW-1:0] speed_t;

  // Register indexes, taken from the word address of the port.
  typedef enum logic [2:0] {
    REG_MAX_VELOCITY    = 3'd0,
    REG_ACCEL_STEP      = 3'd1,
    REG_DECEL_STEP      = 3'd2,
    REG_GRAVITY_STEP    = 3'd3,
    REG_GRAVITY_ENABLE  = 3'd4,
    REG_UPDATE_PERIOD   = 3'd5,
    REG_TRAVEL_PER_STEP = 3'd6
  } svr_reg_e;

endpackage

[rtl/svr_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper ramp channel interfaces
// Valid/ready channels for the tick words going in and the result words out.
// ----------------------------------------------------------------------------

// One 1 us tick with the target speed, contact, load and limit switches.
interface svr_tick_if;
  logic                valid;
  logic                ready;
  svr_pkg::speed_t     target_velocity;
  logic                in_contact;
  logic                no_load;
  logic                limit_top;
  logic                limit_bottom;

  modport source (
    output valid, target_velocity, in_contact, no_load, limit_top, limit_bottom,
    input  ready
  );
  modport sink (
    input  valid, target_velocity, in_contact, no_load, limit_top, limit_bottom,
    output ready
  );
endinterface

// The step decision and the axis state after one tick.
interface svr_res_if;
  logic                valid;
  logic                ready;
  logic                step_pulse;
  logic                direction;
  svr_pkg::speed_t     position;
  svr_pkg::speed_t     speed;
  logic                homed;

  modport source (
    output valid, step_pulse, direction, position, speed, homed,
    input  ready
  );
  modport sink (
    input  valid, step_pulse, direction, position, speed, homed,
    output ready
  );
endinterface

[rtl/stepper_velocity_ramp_stepper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper velocity ramp and step generator
// Ramps the axis speed toward a target once per update period, applies free
// fall and limit switches, and issues a motor step when one is due.
// ----------------------------------------------------------------------------
//
//   Channel   Port      Direction  Contents
//   -------   --------  ---------  --------------------------------------------
//   tick      tick_i    in         target_velocity, in_contact, no_load, limits
//   result    res_o     out        step_pulse, direction, position, speed, homed
//   config    p*        in/out     APB registers 0..6 at byte address 4*index
//
// One tick word per clock while the result channel is not stalled. A word is
// held in the input register; the speed ramp, the 32 by 32 step-rate multiply
// and the 64-bit compare resolve combinationally as it moves into the result register.
// Reset clears speed, position, homed and both tick counters, and loads the
// register reset values. A stalled result keeps its word; a new tick is still
// taken until the input register is also full.

module stepper_velocity_ramp_stepper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  svr_tick_if.sink                     tick_i,
  svr_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [svr_pkg::AddrW-1:0]    paddr,
  input  logic [svr_pkg::DataW-1:0]    pwdata,
  output logic [svr_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  // Configuration registers.
  logic [svr_pkg::RegW-1:0]    max_velocity_q;
  logic [svr_pkg::RegW-1:0]    accel_step_q;
  logic [svr_pkg::RegW-1:0]    decel_step_q;
  logic [svr_pkg::RegW-1:0]    gravity_step_q;
  logic                        gravity_enable_q;
  logic [svr_pkg::PeriodW-1:0] update_period_q;
  logic [svr_pkg::RegW-1:0]    travel_per_step_q;
  logic [svr_pkg::ScaledW-1:0] travel_scaled_q;
  logic                        cfg_wr;
  svr_pkg::svr_reg_e           cfg_reg;

  // Input register.
  logic                        tick_vld_q;
  svr_pkg::speed_t             tgt_q;
  logic                        contact_q;
  logic                        noload_q;
  logic                        ltop_q;
  logic                        lbot_q;

  // Axis state.
  svr_pkg::speed_t             speed_q,  speed_d;
  logic [31:0]                 position_q, position_d;
  logic                        homed_q,  homed_d;
  logic [31:0]                 tsu_q,    tsu_d;
  logic [31:0]                 tss_q,    tss_d;
  logic                        dir_q,    dir_d;
  logic                        pulse_d;

  // Result register.
  logic                        res_vld_q;
  logic                        out_free;
  logic                        advance;

  // Tick datapath.
  logic [31:0]                 tsu_inc;
  logic [31:0]                 tss_inc;
  logic signed [33:0]          maxv;
  logic signed [33:0]          dec;
  logic signed [33:0]          acc;
  logic signed [33:0]          grav;
  logic signed [33:0]          tgt;
  logic signed [33:0]          cur;
  logic signed [33:0]          ramp;
  logic signed [33:0]          spd;
  logic signed [33:0]          spd_abs;
  logic                        due;
  logic                        free_fall;
  logic                        released;
  logic [63:0]                 lhs;
  logic                        step_due;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = svr_pkg::svr_reg_e'(paddr[svr_pkg::AddrW-1:2]);

  // Register writes; the scaled travel is formed here, off the tick path.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_velocity_q    <= '0;
      accel_step_q      <= '0;
      decel_step_q      <= '0;
      gravity_step_q    <= '0;
      gravity_enable_q  <= 1'b0;
      update_period_q   <= svr_pkg::UpdatePeriodRst;
      travel_per_step_q <= svr_pkg::TravelPerStepRst;
      travel_scaled_q   <= svr_pkg::TravelScaledRst;
    end else if (cfg_wr) begin
      case (cfg_reg)
        svr_pkg::REG_MAX_VELOCITY:   max_velocity_q   <= pwdata[svr_pkg::RegW-1:0];
        svr_pkg::REG_ACCEL_STEP:     accel_step_q     <= pwdata[svr_pkg::RegW-1:0];
        svr_pkg::REG_DECEL_STEP:     decel_step_q     <= pwdata[svr_pkg::RegW-1:0];
        svr_pkg::REG_GRAVITY_STEP:   gravity_step_q   <= pwdata[svr_pkg::RegW-1:0];
        svr_pkg::REG_GRAVITY_ENABLE: gravity_enable_q <= pwdata[0];
        svr_pkg::REG_UPDATE_PERIOD:  update_period_q  <= pwdata[svr_pkg::PeriodW-1:0];
        svr_pkg::REG_TRAVEL_PER_STEP: begin
          travel_per_step_q <= pwdata[svr_pkg::RegW-1:0];
          travel_scaled_q   <= svr_pkg::ScaledW'(pwdata[svr_pkg::RegW-1:0])
                               * svr_pkg::ScaledW'(svr_pkg::StepScale);
        end
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    case (cfg_reg)
      svr_pkg::REG_MAX_VELOCITY:    prdata = {1'b0, max_velocity_q};
      svr_pkg::REG_ACCEL_STEP:      prdata = {1'b0, accel_step_q};
      svr_pkg::REG_DECEL_STEP:      prdata = {1'b0, decel_step_q};
      svr_pkg::REG_GRAVITY_STEP:    prdata = {1'b0, gravity_step_q};
      svr_pkg::REG_GRAVITY_ENABLE:  prdata = {31'd0, gravity_enable_q};
      svr_pkg::REG_UPDATE_PERIOD:   prdata = {12'd0, update_period_q};
      svr_pkg::REG_TRAVEL_PER_STEP: prdata = {1'b0, travel_per_step_q};
      default:                      prdata = '0;
    endcase
  end

  // Handshake: the result register frees when empty or taken this cycle.
  assign out_free     = !res_vld_q || res_o.ready;
  assign advance      = tick_vld_q && out_free;
  assign tick_i.ready = !tick_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_vld_q <= 1'b0;
    end else if (tick_i.ready) begin
      tick_vld_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      tgt_q     <= tick_i.target_velocity;
      contact_q <= tick_i.in_contact;
      noload_q  <= tick_i.no_load;
      ltop_q    <= tick_i.limit_top;
      lbot_q    <= tick_i.limit_bottom;
    end
  end

  // Tick counters advance first, saturating at all ones.
  assign tsu_inc = (tsu_q == '1) ? tsu_q : tsu_q + 32'd1;
  assign tss_inc = (tss_q == '1) ? tss_q : tss_q + 32'd1;

  assign maxv = $signed({3'b000, max_velocity_q});
  assign dec  = $signed({3'b000, decel_step_q});
  assign acc  = $signed({3'b000, accel_step_q});
  assign grav = $signed({3'b000, gravity_step_q});
  assign cur  = 34'(speed_q);

  assign due       = tsu_inc > {12'd0, update_period_q};
  assign free_fall = !contact_q && gravity_enable_q && due && noload_q;
  assign released  = !contact_q && !gravity_enable_q;

  // Target clamped above only.
  assign tgt = ($signed(34'(tgt_q)) > maxv) ? maxv : 34'(tgt_q);

  // Ramp one step toward the target; slowing uses the decel step.
  always_comb begin
    ramp = cur;
    if (tgt < cur) begin
      ramp = (cur > 34'sd0) ? cur - dec : cur - acc;
    end else if (tgt > cur) begin
      ramp = (cur < 34'sd0) ? cur + dec : cur + acc;
    end
  end

  // Speed stage: free fall, released, normal update or hold.
  always_comb begin
    spd   = cur;
    tsu_d = tsu_inc;
    if (free_fall) begin
      spd   = (cur - grav < -maxv) ? -maxv : cur - grav;
      tsu_d = '0;
    end else if (released) begin
      spd = '0;
    end else if (due) begin
      tsu_d = '0;
      if (tgt == 34'sd0 && ramp > -dec && ramp < dec) begin
        spd = '0;
      end else if (ramp > maxv) begin
        spd = maxv;
      end else if (ramp < -maxv) begin
        spd = -maxv;
      end else begin
        spd = ramp;
      end
    end
  end

  // Step due when elapsed ticks times speed exceeds the scaled travel.
  assign spd_abs  = (spd < 34'sd0) ? -spd : spd;
  assign lhs      = 64'(tss_inc) * 64'(spd_abs[31:0]);
  assign step_due = (spd != 34'sd0) && (lhs > 64'(travel_scaled_q));

  // Step stage with the limit switches.
  always_comb begin
    speed_d    = spd[31:0];
    position_d = position_q;
    homed_d    = homed_q;
    dir_d      = dir_q;
    tss_d      = tss_inc;
    pulse_d    = 1'b0;
    if (step_due) begin
      tss_d = '0;
      if (spd < 34'sd0) begin
        if (ltop_q) begin
          speed_d = '0;
        end else begin
          dir_d      = 1'b0;
          position_d = position_q + {1'b0, travel_per_step_q};
          pulse_d    = 1'b1;
        end
      end else begin
        if (lbot_q) begin
          speed_d    = '0;
          position_d = '0;
          homed_d    = 1'b1;
        end else begin
          dir_d      = 1'b1;
          position_d = position_q - {1'b0, travel_per_step_q};
          pulse_d    = 1'b1;
        end
      end
    end
  end

  // State update and result register, once per tick moved forward.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q    <= '0;
      position_q <= '0;
      homed_q    <= 1'b0;
      tsu_q      <= '0;
      tss_q      <= '0;
      dir_q      <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (advance) begin
        speed_q    <= speed_d;
        position_q <= position_d;
        homed_q    <= homed_d;
        tsu_q      <= tsu_d;
        tss_q      <= tss_d;
        dir_q      <= dir_d;
      end
      if (out_free) begin
        res_vld_q <= tick_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_o.step_pulse <= pulse_d;
      res_o.direction  <= dir_d;
      res_o.position   <= position_d;
      res_o.speed      <= speed_d;
      res_o.homed      <= homed_d;
    end
  end

  assign res_o.valid = res_vld_q;

endmodule

[rtl/svr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper ramp port checker
// Watches the result channel of the stepper ramp block over time.
// ----------------------------------------------------------------------------
module svr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input logic            step_pulse_i,
  input logic            direction_i,
  input svr_pkg::speed_t position_i,
  input svr_pkg::speed_t speed_i,
  input logic            homed_i
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(step_pulse_i)
      && $stable(direction_i) && $stable(position_i) && $stable(speed_i)
      && $stable(homed_i))
    else $error("result word changed while stalled");

  // An issued step always comes with a moving axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && step_pulse_i |-> speed_i != '0)
    else $error("step issued at zero speed");

  // The direction pin follows the sign of the speed on a step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && step_pulse_i |-> direction_i == !speed_i[31])
    else $error("direction does not match speed sign on a step");

  // Once homed is reported, the next word still reports it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && homed_i |=> !res_valid_i || homed_i)
    else $error("homed flag cleared");

endmodule

bind stepper_velocity_ramp_stepper svr_checker u_svr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .step_pulse_i (res_o.step_pulse),
  .direction_i  (res_o.direction),
  .position_i   (res_o.position),
  .speed_i      (res_o.speed),
  .homed_i      (res_o.homed)
);
